// ===== rtl/assert_macros.svh =====
// Assertion helpers for the cipher block.
// Expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checked in every cycle, reset included.
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/cmpc_pkg.sv =====
`default_nettype none
package cmpc_pkg;

   localparam int FracBits  = 30;
   localparam int MapW      = FracBits + 2;
   localparam int MagW      = FracBits + 1;
   localparam int SeedW     = 32;
   localparam int SeedExtW  = ((MapW > SeedW) ? MapW : SeedW) + 1;
   localparam int KeyScaleW = 11;
   localparam int KeyProdW  = MapW + KeyScaleW;
   localparam int CsrAddrW  = 3;

   localparam logic [SeedW-1:0]            SeedReset = 32'd429497803;
   localparam logic signed [KeyScaleW-1:0] KeyScale  = 11'sd1000;
   localparam logic [MapW-1:0]             OneMap    = MapW'(1) << FracBits;

   // register index, taken from paddr[2]
   localparam logic RegSeed = 1'b0;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } cmpc_req_type;

   typedef struct packed {
      logic [7:0] cipher_pixel;
      logic [7:0] key_byte;
   } cmpc_rsp_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cmpc_map_ctl_type;

   // seed as map value, clamped to [-1, 1]
   function automatic logic signed [MapW-1:0] seed_clamp(input logic [SeedW-1:0] s);
      logic signed [SeedExtW-1:0] se;
      logic signed [SeedExtW-1:0] one_pos;
      logic signed [SeedExtW-1:0] one_neg;
      logic signed [SeedExtW-1:0] res;
      se      = SeedExtW'($signed(s));
      one_pos = SeedExtW'(1) <<< FracBits;
      one_neg = -one_pos;
      if (se > one_pos) begin
         res = one_pos;
      end else if (se < one_neg) begin
         res = one_neg;
      end else begin
         res = se;
      end
      return res[MapW-1:0];
   endfunction

   localparam logic signed [MapW-1:0] SeedMapReset = seed_clamp(SeedReset);

endpackage
`default_nettype wire

// ===== rtl/chaotic_map_pixel_cipher_top.sv =====
// Chaotic-map pixel cipher.
// Input channel req_*: one gray pixel per transfer with a frame-start flag;
// a set flag reloads the map value from the seed register before that pixel.
// Result channel rsp_*: cipher pixel and the key byte used, one per input.
// The seed register is written through the APB-style port at address 0.
// Each pixel passes through the input register, then the map step and key
// compute into the result register.
// Throughput: one pixel per cycle while the result is not stalled; the map
// recurrence t' = 1 - 2t^2 closes through a single square and subtract.
// A stalled result stays in the output register while the input register
// still takes one more pixel; req_stall rises only when both are full.
// Reset clears both valid flags, sets the seed to about 0.400001 and loads
// the map value from it, so pixels before any frame start use that seed.
`default_nettype none
`include "assert_macros.svh"
module chaotic_map_pixel_cipher_top
   import cmpc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire cmpc_req_type        req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      cmpc_rsp_type        rsp_data,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [31:0]         pwdata,
   output      logic [31:0]         prdata,
   output      logic                pready
);

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   cmpc_req_type           s1_data_ff;
   cmpc_req_type           s1_data_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   cmpc_rsp_type           rsp_data_ff;
   cmpc_rsp_type           rsp_data_in;
   logic                   req_accept;
   logic                   advance;
   logic signed [MapW-1:0] seed_map;
   logic [7:0]             key_byte;
   cmpc_map_ctl_type       map_ctl;

   cmpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .seed_map (seed_map)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign map_ctl.load    = s1_data_ff.frame_start;
   assign map_ctl.advance = advance;

   cmpc_map u_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      (map_ctl),
      .seed_map (seed_map),
      .key_byte (key_byte)
   );

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      s1_data_in   = req_accept ? req_data : s1_data_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in.cipher_pixel = s1_data_ff.pixel + key_byte;
         rsp_data_in.key_byte     = key_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_stall_only_full, req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
   `ASSERT_CLK(a_no_drop, (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
   `ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> (!rsp_valid_ff && !s1_valid_ff))

endmodule
`default_nettype wire

// ===== rtl/cmpc_csr.sv =====
`default_nettype none
module cmpc_csr
   import cmpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CsrAddrW-1:0]    paddr,
   input  wire logic [31:0]            pwdata,
   output      logic [31:0]            prdata,
   output      logic                   pready,
   output      logic signed [MapW-1:0] seed_map
);

   logic [SeedW-1:0]        seed_ff;
   logic [SeedW-1:0]        seed_in;
   logic signed [MapW-1:0]  seed_map_ff;
   logic signed [MapW-1:0]  seed_map_in;
   logic                    wr_seed;

   assign pready  = 1'b1;
   assign wr_seed = psel && penable && pwrite && (paddr[2] == RegSeed);

   always_comb begin
      seed_in     = seed_ff;
      seed_map_in = seed_map_ff;
      if (wr_seed) begin
         seed_in     = pwdata;
         seed_map_in = seed_clamp(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= SeedReset;
         seed_map_ff <= SeedMapReset;
      end else begin
         seed_ff     <= seed_in;
         seed_map_ff <= seed_map_in;
      end
   end

   assign prdata   = (paddr[2] == RegSeed) ? seed_ff : 32'd0;
   assign seed_map = seed_map_ff;

endmodule
`default_nettype wire

// ===== rtl/cmpc_map.sv =====
`default_nettype none
`include "assert_macros.svh"
module cmpc_map
   import cmpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmpc_map_ctl_type       ctl,
   input  wire logic signed [MapW-1:0] seed_map,
   output      logic [7:0]             key_byte
);

   logic signed [MapW-1:0]     map_value_ff;
   logic signed [MapW-1:0]     map_value_in;
   logic signed [MapW-1:0]     t_cur;
   logic [MagW-1:0]            mag;
   logic [2*MagW-1:0]          sq_full;
   logic [MagW-1:0]            sq;
   logic signed [KeyProdW-1:0] t_ext;
   logic signed [KeyProdW-1:0] scale_ext;
   logic signed [KeyProdW-1:0] key_prod;
   logic [MapW-1:0]            map_next;

   assign t_cur = ctl.load ? seed_map : map_value_ff;
   assign mag   = t_cur[MapW-1] ? MagW'(-t_cur) : MagW'(t_cur);

   // floor(t * 1000) by arithmetic shift of the signed product
   assign t_ext     = KeyProdW'(t_cur);
   assign scale_ext = KeyProdW'(KeyScale);
   assign key_prod  = t_ext * scale_ext;
   assign key_byte  = key_prod[FracBits +: 8];

   // t' = 1 - 2 * floor(t^2)
   assign sq_full  = mag * mag;
   assign sq       = sq_full[FracBits +: MagW];
   assign map_next = OneMap - {sq, 1'b0};

   assign map_value_in = ctl.advance ? $signed(map_next) : map_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_value_ff <= SeedMapReset;
      end else begin
         map_value_ff <= map_value_in;
      end
   end

   `ASSERT_CLK(a_map_in_range, (map_value_ff <= $signed(OneMap)) && (map_value_ff >= -$signed(OneMap)))
   `ASSERT_CLK(a_map_hold, !ctl.advance |=> $stable(map_value_ff))

endmodule
`default_nettype wire
